@@ hw/rtl/pixel_blob_centroid_clusterer_assert.svh @@
// Assertion macros for the pixel blob centroid clusterer.
// Used by the top level only; simulation builds see the checks, synthesis sees nothing.
`ifndef PIXEL_BLOB_CENTROID_CLUSTERER_ASSERT_SVH
`define PIXEL_BLOB_CENTROID_CLUSTERER_ASSERT_SVH
`ifndef SYNTHESIS
`define PBCC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pbcc check failed");
`define PBCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pbcc check failed");
`else
`define PBCC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PBCC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/pbcc_pkg.sv @@
// Package for the pixel blob centroid clusterer: sizes, constants and shared types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package pbcc_pkg;
   localparam int ZONE_COUNT = 8;
   localparam int ZONE_W     = 3;
   localparam int COORD_W    = 10;
   localparam int SUM_W      = 30;
   localparam int CNT_W      = 21;
   localparam int D2_W       = 21;
   localparam int RSQ_W      = 20;
   localparam int WIDTH_W    = 11;
   localparam int STEP_W     = 4;
   localparam int RSP_DATA_W = 72;

   localparam logic [WIDTH_W-1:0] MAX_WIDTH      = 11'd1024;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET    = 11'd640;
   localparam logic [RSQ_W-1:0]   RSQ_RESET      = 20'd400;
   localparam logic [CNT_W-1:0]   COUNT_CAP      = 21'h100000;
   localparam logic [7:0]         FOREGROUND     = 8'd255;
   localparam logic [ZONE_W-1:0]  LAST_ZONE      = 3'd7;
   localparam logic [STEP_W-1:0]  DIV_LAST_STEP  = 4'd9;

   localparam logic CSR_IMAGE_WIDTH = 1'b0;
   localparam logic CSR_JOIN_RADIUS = 1'b1;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               fg;
      logic               last;
   } item_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_APPLY  = 5'b00100,
      ST_DIVIDE = 5'b01000,
      ST_REPORT = 5'b10000
   } state_type;
endpackage
`default_nettype wire

@@ hw/rtl/pbcc_front.sv @@
// Front end: accepts pixel beats, tracks column and row, tags foreground pixels.
// Depends on pbcc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pbcc_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [pbcc_pkg::WIDTH_W-1:0] image_width,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [7:0]                   req_tdata,
   input  wire logic                         req_tlast,
   input  wire logic                         queue_full,
   output logic                              push,
   output pbcc_pkg::item_type                item
);
   import pbcc_pkg::*;

   logic [COORD_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [WIDTH_W-1:0] width_eff, col_next;

   // Width 0 acts as 1, anything above the maximum as the maximum.
   assign width_eff = (image_width == '0) ? WIDTH_W'(1) :
                      (image_width > MAX_WIDTH) ? MAX_WIDTH : image_width;
   assign col_next  = WIDTH_W'(col_ff) + WIDTH_W'(1);

   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;
   assign item.x     = col_ff;
   assign item.y     = row_ff;
   assign item.fg    = (req_tdata == FOREGROUND);
   assign item.last  = req_tlast;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (push) begin
         if (req_tlast) begin
            col_in = '0;
            row_in = '0;
         end else if (col_next >= width_eff) begin
            col_in = '0;
            row_in = row_ff + COORD_W'(1);
         end else begin
            col_in = col_next[COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end
endmodule
`default_nettype wire

@@ hw/rtl/pbcc_queue.sv @@
// Two-entry queue of classified pixels between the front and back ends.
// Depends on pbcc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pbcc_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  pbcc_pkg::item_type      push_item,
   input  wire logic               pop,
   output logic                    full,
   output logic                    not_empty,
   output pbcc_pkg::item_type      head
);
   import pbcc_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];
   assign count_in  = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_in;
      end
   end
endmodule
`default_nettype wire

@@ hw/rtl/pbcc_back.sv @@
// Back end: zone scan, join/open/drop decision, centroid divider and frame report.
// Depends on pbcc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pbcc_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [pbcc_pkg::RSQ_W-1:0]     radius_sq,
   input  wire logic                           q_not_empty,
   input  pbcc_pkg::item_type                  q_head,
   output logic                                q_pop,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [pbcc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);
   import pbcc_pkg::*;

   state_type state_ff, state_in;
   item_type  cur_ff;
   logic [ZONE_W-1:0]  zidx_ff;
   logic [SUM_W-1:0]   sum_x_ff [ZONE_COUNT];
   logic [SUM_W-1:0]   sum_y_ff [ZONE_COUNT];
   logic [COORD_W-1:0] cx_ff [ZONE_COUNT];
   logic [COORD_W-1:0] cy_ff [ZONE_COUNT];
   logic [CNT_W-1:0]   pts_ff [ZONE_COUNT];
   logic [CNT_W-1:0]   dropped_ff;

   logic               best_ok_ff, empty_ok_ff;
   logic [ZONE_W-1:0]  best_idx_ff, empty_idx_ff;
   logic [D2_W-1:0]    best_d2_ff;

   logic [SUM_W-1:0]   rem_x_ff, rem_y_ff, dvs_ff;
   logic [COORD_W-1:0] q_x_ff, q_y_ff;
   logic [STEP_W-1:0]  step_ff;

   logic [COORD_W-1:0] dx, dy;
   logic [D2_W-1:0]    d2;
   logic               active, join_ok, out_free;
   logic [SUM_W-1:0]   new_sx, new_sy;
   logic [CNT_W-1:0]   new_pts;
   logic [3:0]         found;
   logic               fin_last;

   assign active = (pts_ff[zidx_ff] != '0);
   assign dx = (cx_ff[zidx_ff] > cur_ff.x) ? cx_ff[zidx_ff] - cur_ff.x
                                           : cur_ff.x - cx_ff[zidx_ff];
   assign dy = (cy_ff[zidx_ff] > cur_ff.y) ? cy_ff[zidx_ff] - cur_ff.y
                                           : cur_ff.y - cy_ff[zidx_ff];
   assign d2 = D2_W'(dx * dx) + D2_W'(dy * dy);

   assign join_ok  = best_ok_ff && (best_d2_ff < D2_W'(radius_sq));
   assign new_sx   = sum_x_ff[best_idx_ff] + SUM_W'(cur_ff.x);
   assign new_sy   = sum_y_ff[best_idx_ff] + SUM_W'(cur_ff.y);
   assign new_pts  = pts_ff[best_idx_ff] + CNT_W'(1);
   assign out_free = !rsp_tvalid || rsp_tready;
   assign q_pop    = (state_ff == ST_IDLE) && q_not_empty;
   assign fin_last = cur_ff.last;

   always_comb begin
      found = '0;
      for (int i = 0; i < ZONE_COUNT; i++)
         found = found + {3'b0, (pts_ff[i] != '0)};
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               if (q_head.fg)        state_in = ST_SCAN;
               else if (q_head.last) state_in = ST_REPORT;
            end
         end
         ST_SCAN:  if (zidx_ff == LAST_ZONE) state_in = ST_APPLY;
         ST_APPLY: begin
            if (join_ok && pts_ff[best_idx_ff] < COUNT_CAP) state_in = ST_DIVIDE;
            else state_in = fin_last ? ST_REPORT : ST_IDLE;
         end
         ST_DIVIDE: if (step_ff == '0) state_in = fin_last ? ST_REPORT : ST_IDLE;
         ST_REPORT: if (out_free && zidx_ff == LAST_ZONE) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         zidx_ff    <= '0;
         dropped_ff <= '0;
         rsp_tvalid <= 1'b0;
         for (int i = 0; i < ZONE_COUNT; i++) pts_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == ST_REPORT) && out_free) rsp_tvalid <= 1'b1;
         else if (rsp_tready)                     rsp_tvalid <= 1'b0;
         case (state_ff)
            ST_IDLE:  zidx_ff <= '0;
            ST_SCAN:  if (zidx_ff != LAST_ZONE) zidx_ff <= zidx_ff + ZONE_W'(1);
                      else zidx_ff <= '0;
            ST_APPLY: begin
               if (join_ok) begin
                  if (pts_ff[best_idx_ff] < COUNT_CAP) begin
                     pts_ff[best_idx_ff] <= new_pts;
                     zidx_ff <= best_idx_ff;
                  end else begin
                     zidx_ff <= '0;
                  end
               end else begin
                  zidx_ff <= '0;
                  if (empty_ok_ff) begin
                     pts_ff[empty_idx_ff] <= CNT_W'(1);
                  end else if (dropped_ff < COUNT_CAP) begin
                     dropped_ff <= dropped_ff + CNT_W'(1);
                  end
               end
            end
            ST_DIVIDE: if (step_ff == '0) zidx_ff <= '0;
            ST_REPORT: begin
               if (out_free) begin
                  zidx_ff <= zidx_ff + ZONE_W'(1);
                  if (zidx_ff == LAST_ZONE) begin
                     dropped_ff <= '0;
                     for (int i = 0; i < ZONE_COUNT; i++) pts_ff[i] <= '0;
                  end
               end
            end
            default: zidx_ff <= '0;
         endcase
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            cur_ff      <= q_head;
            best_ok_ff  <= 1'b0;
            empty_ok_ff <= 1'b0;
         end
         ST_SCAN: begin
            if (active) begin
               if (!best_ok_ff || d2 < best_d2_ff) begin
                  best_ok_ff  <= 1'b1;
                  best_idx_ff <= zidx_ff;
                  best_d2_ff  <= d2;
               end
            end else if (!empty_ok_ff) begin
               empty_ok_ff  <= 1'b1;
               empty_idx_ff <= zidx_ff;
            end
         end
         ST_APPLY: begin
            if (join_ok) begin
               if (pts_ff[best_idx_ff] < COUNT_CAP) begin
                  sum_x_ff[best_idx_ff] <= new_sx;
                  sum_y_ff[best_idx_ff] <= new_sy;
                  rem_x_ff <= new_sx;
                  rem_y_ff <= new_sy;
                  dvs_ff   <= SUM_W'({new_pts, 9'b0});
                  step_ff  <= DIV_LAST_STEP;
                  q_x_ff   <= '0;
                  q_y_ff   <= '0;
               end
            end else if (empty_ok_ff) begin
               sum_x_ff[empty_idx_ff] <= SUM_W'(cur_ff.x);
               sum_y_ff[empty_idx_ff] <= SUM_W'(cur_ff.y);
               cx_ff[empty_idx_ff]    <= cur_ff.x;
               cy_ff[empty_idx_ff]    <= cur_ff.y;
            end
         end
         ST_DIVIDE: begin
            // One quotient bit per cycle for each axis; quotient fits 10 bits.
            if (rem_x_ff >= dvs_ff) rem_x_ff <= rem_x_ff - dvs_ff;
            if (rem_y_ff >= dvs_ff) rem_y_ff <= rem_y_ff - dvs_ff;
            q_x_ff  <= {q_x_ff[COORD_W-2:0], (rem_x_ff >= dvs_ff)};
            q_y_ff  <= {q_y_ff[COORD_W-2:0], (rem_y_ff >= dvs_ff)};
            dvs_ff  <= dvs_ff >> 1;
            step_ff <= step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               cx_ff[zidx_ff] <= {q_x_ff[COORD_W-2:0], (rem_x_ff >= dvs_ff)};
               cy_ff[zidx_ff] <= {q_y_ff[COORD_W-2:0], (rem_y_ff >= dvs_ff)};
            end
         end
         ST_REPORT: begin
            if (out_free) begin
               rsp_tuser <= active;
               rsp_tlast <= (zidx_ff == LAST_ZONE);
               rsp_tdata <= {3'b0, dropped_ff, found, pts_ff[zidx_ff],
                             active ? cy_ff[zidx_ff] : COORD_W'(0),
                             active ? cx_ff[zidx_ff] : COORD_W'(0), zidx_ff};
            end
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

@@ hw/rtl/pixel_blob_centroid_clusterer.sv @@
// Top level of the pixel blob centroid clusterer: configuration registers and wiring.
// Depends on pbcc_pkg, pbcc_front, pbcc_queue, pbcc_back and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "pixel_blob_centroid_clusterer_assert.svh"
// Pixels arrive one per beat in raster order; a value of 255 is foreground and is
// placed into one of eight zones: it joins the nearest zone whose truncated
// centroid lies within the join radius (lowest index wins ties), otherwise opens
// the first empty zone, otherwise is counted as dropped. The beat with tlast set
// ends the frame: after its pixel is handled, eight result beats follow, one per
// zone, the last with tlast set, and all zones, counters and the drop count clear.
// Timing: the front end takes a pixel every cycle into a two-entry queue while the
// queue has room. The back end passes a background pixel straight through its idle
// state; a foreground pixel that opens a zone or is dropped takes the eight-zone scan
// and a decision step, and one that joins a zone also runs a radix-2 divider to
// refresh the centroid. The report sends one beat per zone as the result side accepts.
module pixel_blob_centroid_clusterer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wen,
   input  wire logic        csr_addr,
   input  wire logic [10:0] csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // pixel_value[7:0]
   input  wire logic        req_tlast,   // frame_last
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // zone_index[2:0], centroid_x[12:3], centroid_y[22:13], point_count[43:23],
   // zones_found[47:44], points_dropped[68:48], zero pad[71:69]
   output logic [71:0]      rsp_tdata,
   output logic             rsp_tuser,   // zone_valid
   output logic             rsp_tlast    // report_last
);
   import pbcc_pkg::*;

   logic [WIDTH_W-1:0] width_ff;
   logic [RSQ_W-1:0]   rsq_ff;
   logic               q_full, q_not_empty, push, pop;
   item_type           push_item, head;

   // The squared radius is kept instead of the radius itself.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         rsq_ff   <= RSQ_RESET;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_IMAGE_WIDTH: width_ff <= csr_wdata;
            CSR_JOIN_RADIUS: rsq_ff   <= RSQ_W'(csr_wdata[COORD_W-1:0]) *
                                         RSQ_W'(csr_wdata[COORD_W-1:0]);
            default: ;
         endcase
      end
   end

   pbcc_front u_front (
      .clock, .reset, .image_width(width_ff), .req_tvalid, .req_tready,
      .req_tdata, .req_tlast, .queue_full(q_full), .push, .item(push_item)
   );

   pbcc_queue u_queue (
      .clock, .reset, .push, .push_item, .pop, .full(q_full),
      .not_empty(q_not_empty), .head
   );

   pbcc_back u_back (
      .clock, .reset, .radius_sq(rsq_ff), .q_not_empty, .q_head(head), .q_pop(pop),
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast
   );

   // The last report beat always describes the last zone.
   `PBCC_ASSERT_IMPL(a_last_zone, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata[2:0] == LAST_ZONE)
   // An empty zone reports no centroid and no points.
   `PBCC_ASSERT_IMPL(a_empty_zone, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[43:3] == '0)
   // The queue only fills up through an accepted beat.
   `PBCC_ASSERT_IMPL(a_ready_drop, clock, reset, $fell(req_tready), $past(req_tvalid))
endmodule
`default_nettype wire

@@ sim/pixel_blob_centroid_clusterer_tb.sv @@
// Self-checking testbench for the pixel blob centroid clusterer.
// Depends on pbcc_pkg and the pixel_blob_centroid_clusterer top level.
`timescale 1ns / 1ps
`default_nettype none
module pixel_blob_centroid_clusterer_tb;
   import pbcc_pkg::*;

   // One frame report beat as the block should present it.
   typedef struct packed {
      logic [2:0]  zone;
      logic        valid;
      logic [9:0]  cx;
      logic [9:0]  cy;
      logic [20:0] count;
      logic [3:0]  found;
      logic [20:0] dropped;
      logic        last;
   } zone_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wen = 1'b0;
   logic        csr_addr = 1'b0;
   logic [10:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   pixel_blob_centroid_clusterer u_top (
      .clock(clock), .reset(reset),
      .csr_wen(csr_wen), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata),   // pixel_value[7:0]
      .req_tlast(req_tlast),   // frame_last
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),   // zone_index, centroid_x, centroid_y, point_count,
                               // zones_found, points_dropped, zero pad
      .rsp_tuser(rsp_tuser),   // zone_valid
      .rsp_tlast(rsp_tlast)    // report_last
   );

   always #5 clock = ~clock;

   // Predictor state: the shadow copy of the registers, counters and zones.
   logic [10:0] shadow_width;
   logic [9:0]  shadow_radius;
   logic [9:0]  pix_col, pix_row;
   logic [29:0] sum_col [ZONE_COUNT];
   logic [29:0] sum_row [ZONE_COUNT];
   logic [20:0] zone_pts [ZONE_COUNT];
   logic [20:0] drop_cnt;

   zone_report_type pending_reports [$];
   int unsigned  error_count = 0;
   int unsigned  reports_seen = 0;
   int unsigned  pixels_sent = 0;

   // Idling knobs: percent chance of a gap per cycle on each side.
   int unsigned  send_idle_pct = 0;
   int unsigned  recv_stall_pct = 0;
   int unsigned  hold_off_cycles = 0;

   task automatic clear_zones();
      pix_col = '0;
      pix_row = '0;
      drop_cnt = '0;
      for (int i = 0; i < ZONE_COUNT; i++) begin
         sum_col[i] = '0;
         sum_row[i] = '0;
         zone_pts[i] = '0;
      end
   endtask

   // Places one foreground point: nearest zone in radius, else first empty, else drop.
   task automatic place_point(input logic [9:0] px, input logic [9:0] py);
      int   best, empty;
      longint unsigned best_d2, d2, cx, cy, dx, dy, r;
      best = -1;
      empty = -1;
      best_d2 = 0;
      r = shadow_radius;
      for (int i = 0; i < ZONE_COUNT; i++) begin
         if (zone_pts[i] > 0) begin
            cx = sum_col[i] / zone_pts[i];
            cy = sum_row[i] / zone_pts[i];
            dx = (cx > px) ? cx - px : px - cx;
            dy = (cy > py) ? cy - py : py - cy;
            d2 = dx * dx + dy * dy;
            if (best < 0 || d2 < best_d2) begin
               best = i;
               best_d2 = d2;
            end
         end else if (empty < 0) begin
            empty = i;
         end
      end
      if (best >= 0 && best_d2 < r * r) begin
         if (zone_pts[best] < COUNT_CAP) begin
            sum_col[best] += px;
            sum_row[best] += py;
            zone_pts[best]++;
         end
      end else if (empty >= 0) begin
         sum_col[empty] = px;
         sum_row[empty] = py;
         zone_pts[empty] = 1;
      end else if (drop_cnt < COUNT_CAP) begin
         drop_cnt++;
      end
   endtask

   // Advances the predictor by one pixel and queues the frame report on tlast.
   task automatic predict_pixel(input logic [7:0] pix, input logic last);
      int unsigned w, found;
      zone_report_type rep;
      w = shadow_width;
      if (w < 1) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (pix == FOREGROUND) place_point(pix_col, pix_row);
      if (pix_col + 1 >= w) begin
         pix_col = '0;
         pix_row = (pix_row + 1 >= 1024) ? '0 : pix_row + 1'b1;
      end else begin
         pix_col++;
      end
      if (last) begin
         found = 0;
         for (int i = 0; i < ZONE_COUNT; i++) if (zone_pts[i] > 0) found++;
         for (int i = 0; i < ZONE_COUNT; i++) begin
            rep.zone = i[2:0];
            rep.valid = zone_pts[i] > 0;
            rep.cx = rep.valid ? 10'(sum_col[i] / zone_pts[i]) : '0;
            rep.cy = rep.valid ? 10'(sum_row[i] / zone_pts[i]) : '0;
            rep.count = zone_pts[i];
            rep.found = found[3:0];
            rep.dropped = drop_cnt;
            rep.last = (i == ZONE_COUNT - 1);
            pending_reports.push_back(rep);
         end
         clear_zones();
      end
   endtask

   // Offers one pixel beat, with random sender gaps first, and waits for acceptance.
   // Valid stays high after the beat so back-to-back beats need no extra edge.
   task automatic send_pixel(input logic [7:0] pix, input logic last);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pix;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_pixel(pix, last);
      pixels_sent++;
   endtask

   // Register writes happen only with the block idle.
   task automatic write_csr(input logic addr, input logic [10:0] value);
      req_tvalid <= 1'b0;
      csr_wen <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
      if (addr == CSR_IMAGE_WIDTH) shadow_width = value;
      else shadow_radius = value[9:0];
   endtask

   // Waits until every queued report beat has arrived, then lets the back end drain.
   // A join takes longest; the closing wait covers a pixel that does not report.
   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // Receiver: randomly stalls, and honors an explicit long hold-off when asked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_cycles != 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   // Checker: compares each accepted report beat with the oldest prediction.
   always @(posedge clock) begin
      zone_report_type exp_rep;
      zone_report_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[2:0], rsp_tuser, rsp_tdata[12:3], rsp_tdata[22:13],
                rsp_tdata[43:23], rsp_tdata[47:44], rsp_tdata[68:48], rsp_tlast};
         reports_seen++;
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected report beat, actual %p", $time, got);
            error_count++;
         end else begin
            exp_rep = pending_reports.pop_front();
            if (got !== exp_rep || rsp_tdata[71:69] !== 3'b000) begin
               $display("%0t: report mismatch, expected %p, actual %p (pad %b)",
                        $time, exp_rep, got, rsp_tdata[71:69]);
               error_count++;
            end
         end
      end
   end

   // Sends a frame of n pixels, foreground with the given percent chance.
   task automatic send_frame(input int n, input int fg_pct);
      logic [7:0] pix;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99, 0) < fg_pct) pix = FOREGROUND;
         else if ($urandom_range(3, 0) == 0) pix = 8'hFE;
         else pix = 8'($urandom_range(254, 0));
         send_pixel(pix, i == n - 1);
      end
   endtask

   // Directed: reset defaults, then edge pixels, a join radius of one and drops.
   task automatic test_directed();
      // Default width 640 and radius 20: two points in one zone, background bytes.
      send_pixel(8'hFF, 1'b0);
      send_pixel(8'h00, 1'b0);
      send_pixel(8'hFF, 1'b0);
      send_pixel(8'h7F, 1'b0);
      send_pixel(8'h80, 1'b1);
      drain_block();
      // Narrow image, radius one: only distance zero joins, so the ninth point drops.
      write_csr(CSR_IMAGE_WIDTH, 11'd3);
      write_csr(CSR_JOIN_RADIUS, 11'd1);
      for (int i = 0; i < 12; i++) send_pixel(FOREGROUND, i == 11);
      drain_block();
      // Width one: every pixel sits in column zero on its own row.
      write_csr(CSR_IMAGE_WIDTH, 11'd1);
      write_csr(CSR_JOIN_RADIUS, 11'd2);
      for (int i = 0; i < 6; i++) send_pixel(FOREGROUND, i == 5);
      drain_block();
   endtask

   // Random frames across several register settings and idling phases.
   task automatic test_random_frames(input int pixels);
      int sent;
      sent = 0;
      while (sent < pixels) begin
         int n;
         n = $urandom_range(40, 4);
         if (n > pixels - sent) n = pixels - sent;
         case ($urandom_range(3, 0))
            0: write_csr(CSR_IMAGE_WIDTH, 11'($urandom_range(8, 1)));
            1: write_csr(CSR_IMAGE_WIDTH, 11'($urandom_range(2047, 1025)));
            2: write_csr(CSR_IMAGE_WIDTH, 11'd0);
            default: write_csr(CSR_IMAGE_WIDTH, 11'($urandom_range(40, 2)));
         endcase
         case ($urandom_range(3, 0))
            0: write_csr(CSR_JOIN_RADIUS, 11'd1023);
            1: write_csr(CSR_JOIN_RADIUS, 11'd0);
            default: write_csr(CSR_JOIN_RADIUS, 11'($urandom_range(6, 1)));
         endcase
         send_frame(n, $urandom_range(70, 20));
         sent += n;
         drain_block();
      end
   endtask

   // Long receiver hold-off while the sender keeps pushing several frames.
   task automatic test_backpressure();
      write_csr(CSR_IMAGE_WIDTH, 11'd4);
      write_csr(CSR_JOIN_RADIUS, 11'd2);
      hold_off_cycles = 400;
      for (int f = 0; f < 3; f++) send_frame(6, 50);
      drain_block();
   endtask

   initial begin
      shadow_width = WIDTH_RESET;
      shadow_radius = 10'd20;
      clear_zones();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      send_idle_pct = 0;  recv_stall_pct = 0;
      test_random_frames(100);
      send_idle_pct = 71; recv_stall_pct = 0;
      test_random_frames(100);
      send_idle_pct = 0;  recv_stall_pct = 71;
      test_random_frames(100);
      send_idle_pct = 19; recv_stall_pct = 19;
      test_random_frames(80);
      send_idle_pct = 0;  recv_stall_pct = 0;
      test_backpressure();
      // Back to the widest image and radius before the end.
      write_csr(CSR_IMAGE_WIDTH, 11'd1024);
      write_csr(CSR_JOIN_RADIUS, 11'd1023);
      send_frame(10, 60);
      drain_block();
      $display("Covered %0d pixels and %0d report beats over widths, radii and idling phases.",
               pixels_sent, reports_seen);
      if (error_count == 0 && pending_reports.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog: declares failure if the run never finishes.
   initial begin
      #5ms;
      $display("simulation failed");
      $finish;
   end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+hw/rtl
hw/rtl/pbcc_pkg.sv
hw/rtl/pbcc_front.sv
hw/rtl/pbcc_queue.sv
hw/rtl/pbcc_back.sv
hw/rtl/pixel_blob_centroid_clusterer.sv
sim/pixel_blob_centroid_clusterer_tb.sv
